// ===== sv/dfl_pkg.sv =====
// Package for the two-class longest-first FIFO block.
// Holds the port widths, request and status codes, and control structs.
// No dependencies.
`default_nettype none

package dfl_pkg;

   localparam int MODE_W  = 3;
   localparam int TAG_W   = 16;
   localparam int COUNT_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQ_A   = 3'd0,
      MODE_ENQ_B   = 3'd1,
      MODE_DEQ_A   = 3'd2,
      MODE_DEQ_B   = 3'd3,
      MODE_DEQ_ANY = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      CLASS_A = 1'b0,
      CLASS_B = 1'b1
   } class_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/dfl_cell.sv =====
// One storage cell of a queue chain: holds one tag and takes either a new
// tag or its upper neighbor's tag. Depends on dfl_pkg.
`default_nettype none

module dfl_cell
   import dfl_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  wire logic             clock,
   input  wire cell_ctrl_type    ctrl,
   input  wire logic [WIDTH-1:0] load_tag,
   input  wire logic [WIDTH-1:0] shift_tag,
   output logic      [WIDTH-1:0] tag
);

   logic [WIDTH-1:0] tag_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         tag_ff <= load_tag;
      end else if (ctrl.shift) begin
         tag_ff <= shift_tag;
      end
   end

   assign tag = tag_ff;

endmodule

`default_nettype wire

// ===== sv/dfl_queue.sv =====
// One FIFO queue built as a chain of dfl_cell stages with a fill level.
// The oldest tag sits in the first cell; a pop moves every tag one cell down.
// Depends on dfl_pkg and dfl_cell.
`default_nettype none

module dfl_queue
   import dfl_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 16,
   parameter int LEVEL_W = $clog2(DEPTH + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire queue_cmd_type      cmd,
   input  wire logic [WIDTH-1:0]   push_tag,
   output logic      [WIDTH-1:0]   head_tag,
   output logic      [LEVEL_W-1:0] level,
   output logic      [LEVEL_W-1:0] level_next,
   output queue_stat_type          stat
);

   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] level_in;
   logic [WIDTH-1:0]   cell_tag [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type    ctrl;
      logic [WIDTH-1:0] upper_tag;

      assign ctrl.load  = cmd.push && (level_ff == LEVEL_W'(i));
      assign ctrl.shift = cmd.pop;

      if (i == DEPTH - 1) begin : g_last
         assign upper_tag = cell_tag[i];
      end else begin : g_inner
         assign upper_tag = cell_tag[i+1];
      end

      dfl_cell #(
         .WIDTH(WIDTH)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .load_tag (push_tag),
         .shift_tag(upper_tag),
         .tag      (cell_tag[i])
      );
   end

   always_comb begin
      level_in = level_ff;
      if (cmd.push) begin
         level_in = level_ff + LEVEL_W'(1);
      end else if (cmd.pop) begin
         level_in = level_ff - LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   assign head_tag   = cell_tag[0];
   assign level      = level_ff;
   assign level_next = level_in;
   assign stat.full  = (level_ff == LEVEL_W'(DEPTH));
   assign stat.empty = (level_ff == '0);

endmodule

`default_nettype wire

// ===== sv/dual_fifo_longest_first_top.sv =====
// Two-class FIFO with longest-queue-first service, top level.
// Depends on dfl_pkg, dfl_queue and dfl_cell.
//
// Usage:
// The req_ channel carries one request per transaction: enqueue a tag into
// class A or B, dequeue from A or B, or dequeue from whichever queue holds
// more entries (ties go to class A). Every request yields exactly one
// transaction on the rsp_ channel with the served tag, the class, a status
// code and both queue levels after the request.
// rsp_valid is registered and rises in the cycle after a request is accepted.
// Throughput is one request per cycle while the receiver does not stall:
// each request updates one queue chain and its level counter, and the
// response register frees up in the same cycle it is taken.
// When the receiver stalls, the response register holds its transaction and
// req_stall is raised until it is taken.
// Reset is synchronous and active high. It empties both queues and clears
// the response valid flag; no clearing pass is needed, so requests are taken
// in the first cycle after reset.
`default_nettype none

module dual_fifo_longest_first_top
   import dfl_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [TAG_W-1:0]    req_item_tag,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [TAG_W-1:0]         rsp_served_tag,
   output logic                     rsp_served_class,
   output logic [1:0]               rsp_status,
   output logic [COUNT_W-1:0]       rsp_count_a,
   output logic [COUNT_W-1:0]       rsp_count_b
);

   localparam int StoreBits = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
   localparam int LevelW    = $clog2(QUEUE_DEPTH + 1);

   logic                 accept;
   mode_type             mode;
   queue_cmd_type        cmd_a;
   queue_cmd_type        cmd_b;
   queue_stat_type       stat_a;
   queue_stat_type       stat_b;
   logic [StoreBits-1:0] push_tag;
   logic [StoreBits-1:0] head_a;
   logic [StoreBits-1:0] head_b;
   logic [LevelW-1:0]    level_a;
   logic [LevelW-1:0]    level_b;
   logic [LevelW-1:0]    level_next_a;
   logic [LevelW-1:0]    level_next_b;

   logic [StoreBits-1:0] served_tag;
   class_type            served_class;
   status_type           status;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [TAG_W-1:0]     served_tag_ff;
   logic                 served_class_ff;
   status_type           status_ff;
   logic [COUNT_W-1:0]   count_a_ff;
   logic [COUNT_W-1:0]   count_b_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign mode      = mode_type'(req_mode);
   assign push_tag  = StoreBits'(req_item_tag);

   always_comb begin
      cmd_a        = '0;
      cmd_b        = '0;
      served_tag   = '0;
      served_class = CLASS_A;
      status       = STATUS_EMPTY;
      case (mode)
         MODE_ENQ_A: begin
            served_class = CLASS_A;
            if (stat_a.full) begin
               status = STATUS_FULL;
            end else begin
               cmd_a.push = accept;
               status     = STATUS_OK;
            end
         end
         MODE_ENQ_B: begin
            served_class = CLASS_B;
            if (stat_b.full) begin
               status = STATUS_FULL;
            end else begin
               cmd_b.push = accept;
               status     = STATUS_OK;
            end
         end
         MODE_DEQ_A: begin
            served_class = CLASS_A;
            if (!stat_a.empty) begin
               cmd_a.pop  = accept;
               served_tag = head_a;
               status     = STATUS_OK;
            end
         end
         MODE_DEQ_B: begin
            served_class = CLASS_B;
            if (!stat_b.empty) begin
               cmd_b.pop  = accept;
               served_tag = head_b;
               status     = STATUS_OK;
            end
         end
         MODE_DEQ_ANY: begin
            if (!stat_a.empty || !stat_b.empty) begin
               status = STATUS_OK;
               if (level_a >= level_b) begin
                  served_class = CLASS_A;
                  cmd_a.pop    = accept;
                  served_tag   = head_a;
               end else begin
                  served_class = CLASS_B;
                  cmd_b.pop    = accept;
                  served_tag   = head_b;
               end
            end
         end
         default: begin
            status = STATUS_EMPTY;
         end
      endcase
   end

   dfl_queue #(
      .DEPTH  (QUEUE_DEPTH),
      .WIDTH  (StoreBits),
      .LEVEL_W(LevelW)
   ) u_queue_a (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_a),
      .push_tag  (push_tag),
      .head_tag  (head_a),
      .level     (level_a),
      .level_next(level_next_a),
      .stat      (stat_a)
   );

   dfl_queue #(
      .DEPTH  (QUEUE_DEPTH),
      .WIDTH  (StoreBits),
      .LEVEL_W(LevelW)
   ) u_queue_b (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_b),
      .push_tag  (push_tag),
      .head_tag  (head_b),
      .level     (level_b),
      .level_next(level_next_b),
      .stat      (stat_b)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         served_tag_ff   <= TAG_W'(served_tag);
         served_class_ff <= served_class;
         status_ff       <= status;
         count_a_ff      <= COUNT_W'(level_next_a);
         count_b_ff      <= COUNT_W'(level_next_b);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_served_tag   = served_tag_ff;
   assign rsp_served_class = served_class_ff;
   assign rsp_status       = status_ff;
   assign rsp_count_a      = count_a_ff;
   assign rsp_count_b      = count_b_ff;

endmodule

`default_nettype wire

// ===== sv/dfl_checker.sv =====
// Port-level checker for the two-class longest-first FIFO, bound to the top.
// Depends on dfl_pkg and dual_fifo_longest_first_top.
`default_nettype none

module dfl_checker
   import dfl_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [TAG_W-1:0]   rsp_served_tag,
   input wire logic               rsp_served_class,
   input wire logic [1:0]         rsp_status,
   input wire logic [COUNT_W-1:0] rsp_count_a,
   input wire logic [COUNT_W-1:0] rsp_count_b
);

   a_accept_gives_response: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid
   ) else $error("An accepted transaction did not produce a response.");

   a_stalled_response_holds: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_served_tag)
                                    && $stable(rsp_status))
   ) else $error("A stalled response transaction changed.");

   a_full_matches_level: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |->
         ((rsp_served_class == CLASS_A && rsp_count_a == COUNT_W'(QUEUE_DEPTH)) ||
          (rsp_served_class == CLASS_B && rsp_count_b == COUNT_W'(QUEUE_DEPTH)))
   ) else $error("A full status was reported for a queue that is not full.");

   a_empty_b_matches_level: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY && rsp_served_class == CLASS_B) |->
         (rsp_count_b == '0 && rsp_served_tag == '0)
   ) else $error("An empty status on class B was reported with entries present.");

endmodule

bind dual_fifo_longest_first_top dfl_checker #(
   .QUEUE_DEPTH(QUEUE_DEPTH)
) u_dfl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_served_tag  (rsp_served_tag),
   .rsp_served_class(rsp_served_class),
   .rsp_status      (rsp_status),
   .rsp_count_a     (rsp_count_a),
   .rsp_count_b     (rsp_count_b)
);

`default_nettype wire
